// ===== rtl/smc_pkg.sv =====
// Package for the stepper move controller: command and register codes,
// move modes, the axis state record and reset values. No dependencies.
package smc_pkg;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned DIST_W    = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STEPS_W   = 32;
  localparam int unsigned PHASE_W   = 16;

  localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_UP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DOWN = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIST = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_MM = 2'd1;

  localparam logic [CFG_W-1:0] HALF_PERIOD_RESET  = 16'd200;
  localparam logic [CFG_W-1:0] STEPS_PER_MM_RESET = 16'd268;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_UP   = 2'd1,
    MODE_DOWN = 2'd2,
    MODE_DIST = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    logic [STEPS_W-1:0]  steps_left;
    logic [PHASE_W-1:0]  phase;
    logic                pulse;
    logic                dir;
  } axis_state_t;

endpackage

// ===== rtl/smc_step.sv =====
// Next-state logic of the stepper axis for one tick request.
// Depends on smc_pkg for codes and the axis state record.
module smc_step (
  input  smc_pkg::axis_state_t         st,
  input  logic [smc_pkg::CMD_W-1:0]    cmd,
  input  logic [smc_pkg::DIST_W-1:0]   distance_mm,
  input  logic                         move_up,
  input  logic                         lower_limit,
  input  logic                         upper_limit,
  input  logic                         door_closed,
  input  logic [smc_pkg::CFG_W-1:0]    half_period,
  input  logic [smc_pkg::CFG_W-1:0]    steps_per_mm,
  output smc_pkg::axis_state_t         st_nxt,
  output logic                         done
);

  logic chk;
  logic stop_now;
  logic half_over;

  assign half_over = st.phase >= half_period;

  always_comb begin
    st_nxt   = st;
    chk      = 1'b0;
    stop_now = 1'b0;
    done     = 1'b0;
    case (cmd)
      smc_pkg::CMD_UP, smc_pkg::CMD_DOWN, smc_pkg::CMD_DIST: begin
        st_nxt.steps_left = '0;
        st_nxt.phase      = '0;
        st_nxt.pulse      = 1'b0;
        if (cmd == smc_pkg::CMD_UP) begin
          st_nxt.mode = smc_pkg::MODE_UP;
          st_nxt.dir  = 1'b1;
        end else if (cmd == smc_pkg::CMD_DOWN) begin
          st_nxt.mode = smc_pkg::MODE_DOWN;
          st_nxt.dir  = 1'b0;
        end else begin
          st_nxt.mode       = smc_pkg::MODE_DIST;
          st_nxt.dir        = move_up;
          st_nxt.steps_left = smc_pkg::STEPS_W'(distance_mm) *
                              smc_pkg::STEPS_W'(steps_per_mm);
        end
      end
      smc_pkg::CMD_STOP: begin
        st_nxt.mode       = smc_pkg::MODE_IDLE;
        st_nxt.steps_left = '0;
        st_nxt.phase      = '0;
        st_nxt.pulse      = 1'b0;
      end
      default: begin
        // tick, also the unused codes
        if (st.mode != smc_pkg::MODE_IDLE) begin
          if (st.pulse) begin
            if (half_over) begin
              st_nxt.pulse = 1'b0;
              st_nxt.phase = smc_pkg::PHASE_W'(1);
            end else begin
              st_nxt.phase = st.phase + 1'b1;
            end
          end else if (st.phase != '0) begin
            if (half_over) begin
              if (st.mode == smc_pkg::MODE_DIST && st.steps_left != '0) begin
                st_nxt.steps_left = st.steps_left - 1'b1;
              end
              st_nxt.phase = '0;
              chk          = 1'b1;
            end else begin
              st_nxt.phase = st.phase + 1'b1;
            end
          end else begin
            chk = 1'b1;
          end
        end
      end
    endcase

    // pulse boundary: limits, step count and door are judged here only
    if (chk) begin
      case (st.mode)
        smc_pkg::MODE_UP:   stop_now = upper_limit;
        smc_pkg::MODE_DOWN: stop_now = lower_limit;
        smc_pkg::MODE_DIST: stop_now = (st_nxt.steps_left == '0) ||
                                       (st_nxt.dir ? upper_limit : lower_limit);
        default:            stop_now = 1'b0;
      endcase
      if (stop_now) begin
        done              = st.mode == smc_pkg::MODE_DIST;
        st_nxt.mode       = smc_pkg::MODE_IDLE;
        st_nxt.steps_left = '0;
        st_nxt.phase      = '0;
        st_nxt.pulse      = 1'b0;
      end else if (door_closed) begin
        st_nxt.pulse = 1'b1;
        st_nxt.phase = smc_pkg::PHASE_W'(1);
      end
    end
  end

endmodule

// ===== rtl/stepper_move_controller.sv =====
// Stepper axis step/direction generator, one request per time-base tick.
// A result is registered and valid in the cycle after its request is accepted.
// Throughput: one request per cycle; in_ready drops only while a result
// waits unaccepted on the output register.
// Reset (synchronous, rst_n low): axis idle, counters zero, result invalid
// (the pin registers are not reset), half period 200 ticks and 268 steps per mm.
module stepper_move_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [smc_pkg::CMD_W-1:0]       in_cmd,
  input  logic [smc_pkg::DIST_W-1:0]      in_distance_mm,
  input  logic                            in_move_up,
  input  logic                            in_lower_limit,
  input  logic                            in_upper_limit,
  input  logic                            in_door_closed,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_drive_enable,
  output logic                            out_direction_up,
  output logic                            out_step_pulse,
  output logic                            out_busy_res,
  output logic                            out_move_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [smc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [smc_pkg::CFG_W-1:0]       cfg_data
);

  smc_pkg::axis_state_t st_r, st_nxt;
  logic [smc_pkg::CFG_W-1:0] half_period_r;
  logic [smc_pkg::CFG_W-1:0] steps_per_mm_r;
  logic out_valid_r;
  logic active_r, dir_r, pulse_r, done_r;
  logic done;
  logic in_acc;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  smc_step u_step (
    .st           (st_r),
    .cmd          (in_cmd),
    .distance_mm  (in_distance_mm),
    .move_up      (in_move_up),
    .lower_limit  (in_lower_limit),
    .upper_limit  (in_upper_limit),
    .door_closed  (in_door_closed),
    .half_period  (half_period_r),
    .steps_per_mm (steps_per_mm_r),
    .st_nxt       (st_nxt),
    .done         (done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r  <= smc_pkg::HALF_PERIOD_RESET;
      steps_per_mm_r <= smc_pkg::STEPS_PER_MM_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        smc_pkg::REG_HALF_PERIOD:  half_period_r  <= cfg_data;
        smc_pkg::REG_STEPS_PER_MM: steps_per_mm_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode       <= smc_pkg::MODE_IDLE;
      st_r.steps_left <= '0;
      st_r.phase      <= '0;
      st_r.pulse      <= 1'b0;
      st_r.dir        <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      active_r <= st_nxt.mode != smc_pkg::MODE_IDLE;
      dir_r    <= st_nxt.dir;
      pulse_r  <= st_nxt.pulse;
      done_r   <= done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_drive_enable = active_r;
  assign out_direction_up = dir_r;
  assign out_step_pulse   = pulse_r;
  assign out_busy_res     = active_r;
  assign out_move_done    = done_r;

endmodule

// ===== rtl/smc_checker.sv =====
// Port-level checks for stepper_move_controller, attached by bind.
module smc_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_drive_enable,
  input logic out_direction_up,
  input logic out_step_pulse,
  input logic out_busy_res,
  input logic out_move_done
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_drive_enable, out_direction_up, out_step_pulse,
               out_busy_res, out_move_done}))
    else $error("stalled result changed");

  // a finished distance move leaves the axis idle with the pin low
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_done |-> !out_drive_enable && !out_step_pulse)
    else $error("move_done with axis still active");

  a_busy_enable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_busy_res == out_drive_enable)
    else $error("busy and enable disagree");

  // no step pulse without an active move
  a_pulse_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_pulse |-> out_drive_enable)
    else $error("step pulse while idle");

endmodule

bind stepper_move_controller smc_checker u_smc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_drive_enable (out_drive_enable),
  .out_direction_up (out_direction_up),
  .out_step_pulse   (out_step_pulse),
  .out_busy_res     (out_busy_res),
  .out_move_done    (out_move_done)
);
